// ===== rtl/hbc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and arithmetic helpers for the hill block cipher
// no dependencies; imported by the controller, datapath and top level
package hbc_pkg;

  localparam int MaxKeySize   = 4;
  localparam int LetterWidth  = 5;
  localparam int RowWidth     = MaxKeySize * LetterWidth;
  localparam int SizeWidth    = 3;
  localparam int IndexWidth   = 3;
  localparam int ColWidth     = $clog2(MaxKeySize);
  localparam int SumWidth     = 12;
  localparam int ReduceSteps  = 7;

  localparam logic [LetterWidth-1:0] Alphabet  = 5'd26;
  localparam logic [LetterWidth-1:0] PadLetter = 5'd23;
  localparam logic [SizeWidth-1:0]   KeySizeReset = 3'd2;

  // configuration register indexes
  localparam logic [IndexWidth-1:0] CFG_KEY_SIZE  = 3'd0;
  localparam logic [IndexWidth-1:0] CFG_KEY_ROW0  = 3'd1;
  localparam logic [IndexWidth-1:0] CFG_KEY_ROW1  = 3'd2;
  localparam logic [IndexWidth-1:0] CFG_KEY_ROW2  = 3'd3;
  localparam logic [IndexWidth-1:0] CFG_KEY_ROW3  = 3'd4;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_SUM,
    ST_REDUCE,
    ST_SEND
  } hbc_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic store_letter;  // write accepted letter, bump fill count
    logic start_block;   // reset row counter at start of a block
    logic load_sum;      // register dot product of current row
    logic load_out;      // reduce sum into the output register
    logic next_row;      // advance to the next row
    logic finish_block;  // clear fill count after last row
  } hbc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic emit;      // accepted letter completes a block
    logic last_row;  // current row is the final one of the block
  } hbc_status_t;

  // reduce a 5-bit value modulo 26
  function automatic logic [LetterWidth-1:0] mod26_small(input logic [LetterWidth-1:0] x);
    logic [LetterWidth-1:0] r;
    r = (x >= Alphabet) ? (x - Alphabet) : x;
    return r;
  endfunction

  // reduce a dot-product sum modulo 26 by restoring subtraction
  function automatic logic [LetterWidth-1:0] mod26_wide(input logic [SumWidth-1:0] x);
    logic [SumWidth-1:0] r;
    logic [SumWidth-1:0] d;
    r = x;
    for (int k = ReduceSteps - 1; k >= 0; k--) begin
      d = SumWidth'(Alphabet) << k;
      if (r >= d) r = r - d;
    end
    return r[LetterWidth-1:0];
  endfunction

endpackage

// ===== rtl/hbc_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine for the hill block cipher
// depends on hbc_pkg for the state type and command/status structs
module hbc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  output logic                result_valid,
  input  logic                result_ready,
  input  hbc_pkg::hbc_status_t status,
  output hbc_pkg::hbc_cmd_t    cmd
);
  import hbc_pkg::*;

  hbc_state_t state;
  hbc_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: begin
        if (item_valid && status.emit) state_next = ST_SUM;
      end
      ST_SUM:    state_next = ST_REDUCE;
      ST_REDUCE: state_next = ST_SEND;
      ST_SEND: begin
        if (result_ready) begin
          state_next = status.last_row ? ST_COLLECT : ST_SUM;
        end
      end
      default:   state_next = ST_COLLECT;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    item_ready   = 1'b0;
    result_valid = 1'b0;
    cmd          = '0;
    case (state)
      ST_COLLECT: begin
        item_ready       = 1'b1;
        cmd.store_letter = item_valid;
        cmd.start_block  = item_valid && status.emit;
      end
      ST_SUM:    cmd.load_sum = 1'b1;
      ST_REDUCE: cmd.load_out = 1'b1;
      ST_SEND: begin
        result_valid     = 1'b1;
        cmd.next_row     = result_ready && !status.last_row;
        cmd.finish_block = result_ready && status.last_row;
      end
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/hbc_datapath.sv =====
`timescale 1ns / 1ps
// datapath: key registers, block store, row dot product and mod 26 reduction
// depends on hbc_pkg for constants, helper functions and command/status structs
module hbc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [hbc_pkg::IndexWidth-1:0]      cfg_index,
  input  logic [hbc_pkg::RowWidth-1:0]        cfg_data,
  input  logic [hbc_pkg::LetterWidth-1:0]     letter_in,
  input  logic                                message_end,
  input  hbc_pkg::hbc_cmd_t                   cmd,
  output hbc_pkg::hbc_status_t                status,
  output logic [hbc_pkg::LetterWidth-1:0]     letter_out,
  output logic                                block_end
);
  import hbc_pkg::*;

  logic [SizeWidth-1:0]   key_size;
  logic [RowWidth-1:0]    key_rows [MaxKeySize];
  logic [LetterWidth-1:0] block_store [MaxKeySize];
  logic [SizeWidth-1:0]   fill_count;
  logic [SizeWidth-1:0]   fill_next;
  logic [ColWidth-1:0]    row;
  logic [SumWidth-1:0]    sum;
  logic [SumWidth-1:0]    sum_next;
  logic [SizeWidth-1:0]   eff_size;

  // effective block length, clamped to one through the maximum
  always_comb begin
    if (key_size == '0) begin
      eff_size = SizeWidth'(1);
    end else if (key_size > SizeWidth'(MaxKeySize)) begin
      eff_size = SizeWidth'(MaxKeySize);
    end else begin
      eff_size = key_size;
    end
  end

  assign fill_next       = fill_count + SizeWidth'(1);
  assign status.emit     = (fill_next >= eff_size) || message_end;
  assign status.last_row = ((SizeWidth'(row) + SizeWidth'(1)) == eff_size);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_size <= KeySizeReset;
      for (int i = 0; i < MaxKeySize; i++) key_rows[i] <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_KEY_SIZE: key_size    <= cfg_data[SizeWidth-1:0];
        CFG_KEY_ROW0: key_rows[0] <= cfg_data;
        CFG_KEY_ROW1: key_rows[1] <= cfg_data;
        CFG_KEY_ROW2: key_rows[2] <= cfg_data;
        CFG_KEY_ROW3: key_rows[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // block store, written at the fill position
  always_ff @(posedge clk) begin
    if (cmd.store_letter) begin
      block_store[fill_count[ColWidth-1:0]] <= mod26_small(letter_in);
    end
  end

  // fill count and row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      row        <= '0;
    end else begin
      if (cmd.store_letter) fill_count <= fill_next;
      if (cmd.finish_block) fill_count <= '0;
      if (cmd.start_block) begin
        row <= '0;
      end else if (cmd.next_row) begin
        row <= row + ColWidth'(1);
      end
    end
  end

  // dot product of the current key row with the block, pad past the fill
  always_comb begin
    logic [LetterWidth-1:0]   k;
    logic [LetterWidth-1:0]   b;
    logic [2*LetterWidth-1:0] p;
    sum_next = '0;
    for (int j = 0; j < MaxKeySize; j++) begin
      k = mod26_small(key_rows[row][j*LetterWidth +: LetterWidth]);
      b = (SizeWidth'(j) < fill_count) ? block_store[j] : PadLetter;
      p = (SizeWidth'(j) < eff_size) ? (k * b) : '0;
      sum_next = sum_next + SumWidth'(p);
    end
  end

  // sum register, then reduced result register
  always_ff @(posedge clk) begin
    if (cmd.load_sum) sum <= sum_next;
    if (cmd.load_out) begin
      letter_out <= mod26_wide(sum);
      block_end  <= status.last_row;
    end
  end

endmodule

// ===== rtl/hill_block_cipher_unit.sv =====
`timescale 1ns / 1ps
// top level of the hill block cipher: controller plus datapath
// depends on hbc_pkg, hbc_ctrl and hbc_datapath
//
// Usage:
//   Letters (0..25) enter on the item channel (item_valid/item_ready), with
//   message_end high on the last letter of a message. Letters are collected
//   into a block of key_size letters. When a block fills, or the message
//   ends (the rest padded with 'x'), the block is multiplied by the key
//   matrix mod 26 and key_size letters leave on the result channel
//   (result_valid/result_ready), block_end marking the last one.
//   A letter that does not complete a block is taken in the collect state. Each
//   row of a completed block is then processed in turn (row dot product,
//   mod 26 reduction, output transfer when the receiver is ready) by the
//   single shared dot-product unit.
//   item_ready is low while a block is being emitted; a stalled receiver
//   holds the current result and the block in place.
//   The cfg channel is always ready; write key_size (index 0) and the four
//   key rows (indexes 1..4) only while the block is idle.
//   Reset clears key_size to 2, the key rows to zero and the fill count.
module hill_block_cipher_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hbc_pkg::IndexWidth-1:0]  cfg_index,
  input  logic [hbc_pkg::RowWidth-1:0]    cfg_data,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic [hbc_pkg::LetterWidth-1:0] letter_in,
  input  logic                            message_end,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [hbc_pkg::LetterWidth-1:0] letter_out,
  output logic                            block_end
);
  import hbc_pkg::*;

  hbc_cmd_t    cmd;
  hbc_status_t status;

  assign cfg_ready = 1'b1;

  // sequencing
  hbc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // storage and arithmetic
  hbc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .letter_in   (letter_in),
    .message_end (message_end),
    .cmd         (cmd),
    .status      (status),
    .letter_out  (letter_out),
    .block_end   (block_end)
  );

  // no letter is taken while a result is on offer
  assert property (@(posedge clk) disable iff (rst) result_valid |-> !item_ready)
    else $error("item accepted while result pending");

  // results are always reduced letters
  assert property (@(posedge clk) disable iff (rst) result_valid |-> (letter_out < Alphabet))
    else $error("result letter out of range");

  // end of a block returns to collecting
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && block_end) |=> item_ready)
    else $error("block end did not return to collecting");

  // a completing letter leads to a result after the sum and reduce states
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && status.emit) |-> ##3 result_valid)
    else $error("completed block produced no result");

endmodule

// ===== tb/hill_block_cipher_unit_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for hill_block_cipher_unit: directed and random letters
// checked against a built-in block predictor; depends on hbc_pkg and the unit
module hill_block_cipher_unit_tb;
  import hbc_pkg::*;

  localparam int SettleCycles = 8;
  localparam int HoldCycles   = 300;
  localparam int DrainLimit   = 20000;
  localparam int PhaseLetters = 24;
  localparam int StallLetters = 20;

  typedef struct packed {
    logic [LetterWidth-1:0] letter;
    logic                   is_last;
  } cipher_letter_t;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [IndexWidth-1:0]  cfg_index    = '0;
  logic [RowWidth-1:0]    cfg_data     = '0;
  logic                   item_valid   = 1'b0;
  logic                   item_ready;
  logic [LetterWidth-1:0] letter_in    = '0;
  logic                   message_end  = 1'b0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  logic [LetterWidth-1:0] letter_out;
  logic                   block_end;

  // mirror of the unit's registers and block state
  logic [SizeWidth-1:0]   key_size_mirror = KeySizeReset;
  logic [RowWidth-1:0]    key_row_mirror [MaxKeySize] = '{default: '0};
  logic [LetterWidth-1:0] block_mirror   [MaxKeySize] = '{default: '0};
  logic [SizeWidth-1:0]   fill_mirror     = '0;

  cipher_letter_t cipher_expect_q[$];

  logic idle_on   = 1'b1;
  int   hold_left = 0;
  int   letters_sent    = 0;
  int   results_checked = 0;
  int   reg_writes      = 0;
  int   mismatches      = 0;

  hill_block_cipher_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .letter_in    (letter_in),
    .message_end  (message_end),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .letter_out   (letter_out),
    .block_end    (block_end)
  );

  always #1 clk = ~clk;

  // run limit
  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  // key entry reduced mod 26, column c in bits 5c+4..5c
  function automatic int key_entry(input int row, input int col);
    return int'(key_row_mirror[row][LetterWidth*col +: LetterWidth]) % int'(Alphabet);
  endfunction

  // block length after clamping key_size into 1..max
  function automatic int active_size();
    int n;
    n = int'(key_size_mirror);
    if (n < 1) n = 1;
    if (n > MaxKeySize) n = MaxKeySize;
    return n;
  endfunction

  // collect one letter and queue the cipher letters of a finished block
  task automatic encipher_letter(input logic [LetterWidth-1:0] raw, input logic is_last);
    int n;
    int sum;
    logic [LetterWidth-1:0] letter;
    cipher_letter_t out_letter;
    n = active_size();
    letter = LetterWidth'(int'(raw) % int'(Alphabet));
    if (fill_mirror < MaxKeySize) block_mirror[fill_mirror] = letter;
    fill_mirror = fill_mirror + 1'b1;
    if (fill_mirror < n && !is_last) return;
    // pad a short block with 'x'
    for (int i = int'(fill_mirror); i < n; i++) block_mirror[i] = PadLetter;
    for (int i = 0; i < n; i++) begin
      sum = 0;
      for (int j = 0; j < n; j++) begin
        sum = (sum + key_entry(i, j) * int'(block_mirror[j])) % int'(Alphabet);
      end
      out_letter.letter  = LetterWidth'(sum);
      out_letter.is_last = (i == n - 1);
      cipher_expect_q.push_back(out_letter);
    end
    fill_mirror = '0;
  endtask

  function automatic logic [LetterWidth-1:0] rand_letter();
    if ($urandom_range(0, 7) == 0) return LetterWidth'($urandom_range(26, 31));
    return LetterWidth'($urandom_range(0, 25));
  endfunction

  function automatic logic [RowWidth-1:0] pack_row(input logic [LetterWidth-1:0] c0, c1, c2, c3);
    return {c3, c2, c1, c0};
  endfunction

  // one letter transfer; valid stays high on return so a back-to-back letter
  // keeps it up, and wait_idle lowers it
  task automatic send_letter(input logic [LetterWidth-1:0] letter, input logic is_last);
    int gap;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    letter_in   <= letter;
    message_end <= is_last;
    do @(posedge clk); while (!item_ready);
    encipher_letter(letter, is_last);
    letters_sent++;
  endtask

  task automatic write_reg(input logic [IndexWidth-1:0] index, input logic [RowWidth-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (index == CFG_KEY_SIZE) begin
      key_size_mirror = data[SizeWidth-1:0];
    end else if (index >= CFG_KEY_ROW0 && index <= CFG_KEY_ROW3) begin
      key_row_mirror[index - CFG_KEY_ROW0] = data;
    end
    cfg_valid <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  // drop valid, wait for all cipher letters, then let the unit settle
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (cipher_expect_q.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic load_key(input logic [SizeWidth-1:0] size,
                          input logic [RowWidth-1:0] r0, r1, r2, r3);
    wait_idle();
    write_reg(CFG_KEY_SIZE, RowWidth'(size));
    write_reg(CFG_KEY_ROW0, r0);
    write_reg(CFG_KEY_ROW1, r1);
    write_reg(CFG_KEY_ROW2, r2);
    write_reg(CFG_KEY_ROW3, r3);
  endtask

  // reset key: size 2, zero rows; message ends on a full block, then a lone letter
  task automatic test_reset_state();
    send_letter(5'd0, 1'b0);
    send_letter(5'd25, 1'b1);
    send_letter(5'd31, 1'b1);
  endtask

  // saturated and out-of-range key entries, full block and padded block
  task automatic test_extreme_keys();
    load_key(3'd4, '1, pack_row(5'd25, 5'd25, 5'd25, 5'd25), '0,
             pack_row(5'd0, 5'd1, 5'd26, 5'd31));
    repeat (4) send_letter(5'd25, 1'b0);
    send_letter(5'd0, 1'b0);
    send_letter(5'd31, 1'b1);
  endtask

  // key_size of zero and above the maximum are clamped
  task automatic test_key_size_range();
    logic [SizeWidth-1:0] sizes [4];
    sizes = '{3'd0, 3'd5, 3'd1, 3'd7};
    load_key(3'd3, RowWidth'($urandom), RowWidth'($urandom), RowWidth'($urandom),
             RowWidth'($urandom));
    foreach (sizes[k]) begin
      wait_idle();
      write_reg(CFG_KEY_SIZE, RowWidth'(sizes[k]));
      send_letter(LetterWidth'($urandom_range(0, 31)), 1'b0);
      send_letter(LetterWidth'($urandom_range(0, 31)), 1'b1);
    end
  endtask

  // writes to unused indexes change nothing
  task automatic test_unknown_index();
    wait_idle();
    for (int idx = int'(CFG_KEY_ROW3) + 1; idx < (1 << IndexWidth); idx++) begin
      write_reg(IndexWidth'(idx), RowWidth'($urandom));
    end
    send_letter(rand_letter(), 1'b0);
    send_letter(rand_letter(), 1'b1);
  endtask

  // shrinking key_size below the fill count emits on the next letter
  task automatic test_shrink_mid_block();
    load_key(3'd4, RowWidth'($urandom), RowWidth'($urandom), RowWidth'($urandom),
             RowWidth'($urandom));
    repeat (3) send_letter(rand_letter(), 1'b0);
    wait_idle();
    write_reg(CFG_KEY_SIZE, RowWidth'(3'd2));
    send_letter(rand_letter(), 1'b0);
  endtask

  // random messages under several keys, with and without idling
  task automatic test_random_messages();
    logic [SizeWidth-1:0] size;
    int sent;
    int len;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: size = 3'd4;
        1: size = 3'd1;
        3: size = 3'd3;
        4: size = 3'd2;
        5: size = 3'd7;
        default: size = SizeWidth'($urandom_range(0, 7));
      endcase
      if (phase == 4) begin
        load_key(size, '1, '1, '1, '1);
      end else begin
        load_key(size, RowWidth'($urandom), RowWidth'($urandom), RowWidth'($urandom),
                 RowWidth'($urandom));
      end
      idle_on = (phase != 1 && phase != 4);
      sent = 0;
      while (sent < PhaseLetters) begin
        len = $urandom_range(1, 9);
        if ($urandom_range(0, 5) == 0) begin
          // stray letter with no message end
          send_letter(rand_letter(), 1'b0);
          sent++;
        end else begin
          for (int i = 0; i < len; i++) send_letter(rand_letter(), i == len - 1);
          sent += len;
        end
      end
    end
    wait_idle();
    idle_on = 1'b1;
  endtask

  // receiver holds off while letters keep coming, so the input stalls
  task automatic test_receiver_stall();
    load_key(3'd4, RowWidth'($urandom), RowWidth'($urandom), RowWidth'($urandom),
             RowWidth'($urandom));
    idle_on = 1'b0;
    hold_left <= HoldCycles;
    for (int i = 0; i < StallLetters; i++) send_letter(rand_letter(), i == StallLetters - 1);
    wait_idle();
    idle_on = 1'b1;
  endtask

  // long hold-off countdown
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // result ready with a random wait per transfer
  initial begin : drive_result_ready
    int ready_wait;
    ready_wait = 0;
    forever begin
      @(posedge clk);
      if (result_valid && result_ready) ready_wait = idle_on ? $urandom_range(0, 12) : 0;
      if (hold_left > 0) begin
        result_ready <= 1'b0;
      end else if (ready_wait > 0) begin
        result_ready <= 1'b0;
        ready_wait--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // compare each result transfer with the oldest expected cipher letter
  always @(posedge clk) begin : check_results
    cipher_letter_t want;
    if (!rst && result_valid && result_ready) begin
      results_checked++;
      if (cipher_expect_q.size() == 0) begin
        flag_error($sformatf("unexpected result letter %0d block_end %0b",
                             letter_out, block_end));
      end else begin
        want = cipher_expect_q.pop_front();
        if (letter_out !== want.letter || block_end !== want.is_last) begin
          flag_error($sformatf("expected letter %0d block_end %0b, got letter %0d block_end %0b",
                               want.letter, want.is_last, letter_out, block_end));
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_extreme_keys();
    test_key_size_range();
    test_unknown_index();
    test_shrink_mid_block();
    test_random_messages();
    test_receiver_stall();
    // bounded final drain
    item_valid <= 1'b0;
    for (int c = 0; c < DrainLimit && cipher_expect_q.size() > 0; c++) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (cipher_expect_q.size() != 0) begin
      flag_error($sformatf("%0d expected cipher letters never arrived", cipher_expect_q.size()));
    end
    $display("sent %0d letters, checked %0d cipher letters, %0d register writes, %0d mismatches",
             letters_sent, results_checked, reg_writes, mismatches);
    $display("covered clamped key sizes, padded and full blocks, key shrink mid-block, long stall");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
